FILE: design/sdcp_pkg.sv
// ----------------------------------------------------------------------------
// sdcp_pkg: shared types and constants of the serial duty command parser
// Character codes, event codes, first-character classes and the structs that
// carry the parser state and one result between the modules.
// ----------------------------------------------------------------------------
package sdcp_pkg;

    // Event codes reported with every result.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_SET      = 3'd1;
    localparam logic [2:0] EV_INVALID  = 3'd2;
    localparam logic [2:0] EV_SAMPLE   = 3'd3;
    localparam logic [2:0] EV_TOO_LONG = 3'd4;

    // Class of the first character of a line.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_AUTO  = 2'd2;

    // Opcodes of an input transaction.
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_S_UP  = 8'h53;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] DUTY_MAX = 16'd255;

    typedef struct packed {
        logic [1:0]  first_kind;
        logic [15:0] digit_accum;
        logic        digits_ok;
        logic        override_flag;
        logic [7:0]  manual_duty;
        logic [9:0]  last_sample;
    } t_state;

    typedef struct packed {
        logic [2:0] event_code;
        logic [7:0] accepted_value;
        logic [7:0] duty;
        logic       manual_mode;
    } t_result;

endpackage

FILE: design/serial_duty_command_parser_top.sv
// ----------------------------------------------------------------------------
// serial_duty_command_parser_top: serial duty command parser
// Assembles received serial bytes into command lines that pick a manual PWM
// duty or hand control back to the converter sample, which sets sample / 4.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction: a serial byte
//   (i_opcode = 0, i_rx_byte) or a converter sample (i_opcode = 1,
//   i_adc_sample). Every input transaction yields exactly one result on the
//   output channel (o_valid / i_ready): the event code, the accepted value,
//   the duty in force and the manual-mode flag.
//   An accepted transaction is captured in an input register, then the
//   parser logic updates the line state and fills the result register,
//   which drives o_valid and the result until the receiver takes it.
//   Throughput is one transaction per cycle while the receiver keeps up; the
//   state update of the parser is the only loop, so nothing else limits it.
//   When the receiver stalls, the result register holds its value and the
//   input register still takes one more transaction, after which o_ready
//   drops until the result is taken.
//   Reset empties both registers, clears the line, selects sample control
//   and sets the stored sample and the manual duty to zero.
// ----------------------------------------------------------------------------
module serial_duty_command_parser_top #(
    parameter int LINE_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    input  logic [9:0] i_adc_sample,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_code,
    output logic [7:0] o_accepted_value,
    output logic [7:0] o_duty,
    output logic       o_manual_mode
);

    localparam int LW = $clog2(LINE_BYTES);

    // Input register.
    logic       r_in_valid;
    logic       r_opcode;
    logic [7:0] r_rx_byte;
    logic [9:0] r_adc_sample;

    // Parser state.
    logic [LW-1:0]    r_line_len;
    logic [LW-1:0]    n_line_len;
    sdcp_pkg::t_state r_state;
    sdcp_pkg::t_state n_state;

    // Result register.
    logic              r_out_valid;
    sdcp_pkg::t_result r_result;
    sdcp_pkg::t_result n_result;

    logic advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    sdcp_step #(
        .LINE_BYTES (LINE_BYTES)
    ) u_step (
        .i_opcode     (r_opcode),
        .i_rx_byte    (r_rx_byte),
        .i_adc_sample (r_adc_sample),
        .i_line_len   (r_line_len),
        .i_state      (r_state),
        .o_line_len   (n_line_len),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_opcode     <= i_opcode;
            r_rx_byte    <= i_rx_byte;
            r_adc_sample <= i_adc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len            <= '0;
            r_state.first_kind    <= sdcp_pkg::KIND_OTHER;
            r_state.digit_accum   <= 16'd0;
            r_state.digits_ok     <= 1'b1;
            r_state.override_flag <= 1'b0;
            r_state.manual_duty   <= 8'd0;
            r_state.last_sample   <= 10'd0;
        end else if (advance) begin
            r_line_len <= n_line_len;
            r_state    <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_code     = r_result.event_code;
    assign o_accepted_value = r_result.accepted_value;
    assign o_duty           = r_result.duty;
    assign o_manual_mode    = r_result.manual_mode;

    // A line that sets a duty leaves the block in manual mode at that value.
    a_set_applies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_code == sdcp_pkg::EV_SET)
            |-> (o_manual_mode && o_duty == o_accepted_value))
        else $error("duty set did not take effect");

    // Only a duty-set result carries a value.
    a_value_only_on_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_code != sdcp_pkg::EV_SET) |-> (o_accepted_value == 8'd0))
        else $error("accepted value reported without a duty set");

    // Returning to sample control clears manual mode.
    a_sample_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_code == sdcp_pkg::EV_SAMPLE) |-> !o_manual_mode)
        else $error("sample mode reported while manual");

    // The stored line never reaches the full line length.
    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_len <= LW'(LINE_BYTES - 1))
        else $error("line length out of range");

    // A result that was not taken is not overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_result)))
        else $error("pending result was overwritten");

endmodule

FILE: design/sdcp_step.sv
// ----------------------------------------------------------------------------
// sdcp_step: next-state and result logic of the command parser
// Takes one transaction and the current parser state and produces the state
// after it together with the result that it reports.
// ----------------------------------------------------------------------------
module sdcp_step #(
    parameter int LINE_BYTES = 16
) (
    input  logic                          i_opcode,
    input  logic [7:0]                    i_rx_byte,
    input  logic [9:0]                    i_adc_sample,
    input  logic [$clog2(LINE_BYTES)-1:0] i_line_len,
    input  sdcp_pkg::t_state              i_state,
    output logic [$clog2(LINE_BYTES)-1:0] o_line_len,
    output sdcp_pkg::t_state              o_state,
    output sdcp_pkg::t_result             o_result
);

    localparam int LW = $clog2(LINE_BYTES);
    localparam logic [LW-1:0] LEN_LAST = LW'(LINE_BYTES - 1);

    logic [15:0] accum_x10;
    logic [15:0] accum_next;
    logic [3:0]  digit_val;

    // Multiply by ten as (x << 3) + (x << 1), wrapping at 16 bits.
    assign digit_val  = 4'(i_rx_byte - sdcp_pkg::CH_ZERO);
    assign accum_x10  = {i_state.digit_accum[12:0], 3'b000}
                      + {i_state.digit_accum[14:0], 1'b0};
    assign accum_next = accum_x10 + {12'd0, digit_val};

    always_comb begin
        o_line_len = i_line_len;
        o_state    = i_state;
        o_result.event_code     = sdcp_pkg::EV_NONE;
        o_result.accepted_value = 8'd0;

        if (i_opcode == sdcp_pkg::OP_SAMPLE) begin
            o_state.last_sample = i_adc_sample;
        end else if (i_rx_byte inside {sdcp_pkg::CH_CR, sdcp_pkg::CH_LF}) begin
            if (i_line_len != '0) begin
                if (i_state.first_kind == sdcp_pkg::KIND_SET) begin
                    if (i_state.digits_ok && i_state.digit_accum <= sdcp_pkg::DUTY_MAX) begin
                        o_state.manual_duty     = i_state.digit_accum[7:0];
                        o_state.override_flag   = 1'b1;
                        o_result.event_code     = sdcp_pkg::EV_SET;
                        o_result.accepted_value = i_state.digit_accum[7:0];
                    end else begin
                        o_result.event_code = sdcp_pkg::EV_INVALID;
                    end
                end else if (i_state.first_kind == sdcp_pkg::KIND_AUTO) begin
                    o_state.override_flag = 1'b0;
                    o_result.event_code   = sdcp_pkg::EV_SAMPLE;
                end
            end
            o_line_len          = '0;
            o_state.first_kind  = sdcp_pkg::KIND_OTHER;
            o_state.digit_accum = 16'd0;
            o_state.digits_ok   = 1'b1;
        end else if (i_line_len < LEN_LAST) begin
            if (i_line_len == '0) begin
                if (i_rx_byte inside {sdcp_pkg::CH_S_UP, sdcp_pkg::CH_S_LO}) begin
                    o_state.first_kind = sdcp_pkg::KIND_SET;
                end else if (i_rx_byte inside {sdcp_pkg::CH_A_UP, sdcp_pkg::CH_A_LO}) begin
                    o_state.first_kind = sdcp_pkg::KIND_AUTO;
                end else begin
                    o_state.first_kind = sdcp_pkg::KIND_OTHER;
                end
            end else if (i_state.digits_ok) begin
                if (i_rx_byte inside {[sdcp_pkg::CH_ZERO:sdcp_pkg::CH_NINE]}) begin
                    o_state.digit_accum = accum_next;
                end else begin
                    o_state.digits_ok = 1'b0;
                end
            end
            o_line_len = i_line_len + LW'(1);
        end else begin
            // The line is full and this byte is not a terminator: drop the line.
            o_line_len          = '0;
            o_state.first_kind  = sdcp_pkg::KIND_OTHER;
            o_state.digit_accum = 16'd0;
            o_state.digits_ok   = 1'b1;
            o_result.event_code = sdcp_pkg::EV_TOO_LONG;
        end

        o_result.manual_mode = o_state.override_flag;
        o_result.duty = o_state.override_flag ? o_state.manual_duty
                                              : o_state.last_sample[9:2];
    end

endmodule

FILE: sim/serial_duty_command_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_duty_command_parser_top_test: self-checking bench of the duty parser
// A queue-fed driver offers serial bytes and converter samples, and a
// line-level predictor computes the event, accepted value, duty and mode of
// every transaction. A monitor checks each result in order against it, under
// phases of sender idling, receiver stalling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module serial_duty_command_parser_top_test;

    localparam int LINE_BYTES  = 16;
    localparam int LONG_HOLD   = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 470;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [9:0] adc_sample;
    } t_cmd_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_opcode = sdcp_pkg::OP_BYTE;
    logic [7:0] i_rx_byte = 8'd0;
    logic [9:0] i_adc_sample = 10'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_event_code;
    logic [7:0] o_accepted_value;
    logic [7:0] o_duty;
    logic       o_manual_mode;

    t_cmd_item         pending_commands[$];
    sdcp_pkg::t_result expected_reports[$];
    int        queued_total = 0;
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    logic      hold_request = 1'b0;
    logic      hold_taken = 1'b0;
    int        hold_left = 0;
    t_cmd_item next_cmd;

    // Parser state as the predictor sees it.
    int          line_len = 0;
    logic [1:0]  first_kind = sdcp_pkg::KIND_OTHER;
    logic [15:0] digit_accum = 16'd0;
    logic        digits_ok = 1'b1;
    logic        manual_override = 1'b0;
    logic [7:0]  manual_duty = 8'd0;
    logic [9:0]  last_sample = 10'd0;

    serial_duty_command_parser_top #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_rx_byte        (i_rx_byte),
        .i_adc_sample     (i_adc_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_code     (o_event_code),
        .o_accepted_value (o_accepted_value),
        .o_duty           (o_duty),
        .o_manual_mode    (o_manual_mode)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic restart_line();
        line_len    = 0;
        first_kind  = sdcp_pkg::KIND_OTHER;
        digit_accum = 16'd0;
        digits_ok   = 1'b1;
    endtask

    task automatic advance_parser(input logic op, input logic [7:0] ch,
                                  input logic [9:0] smp);
        sdcp_pkg::t_result res;
        res.event_code     = sdcp_pkg::EV_NONE;
        res.accepted_value = 8'd0;
        if (op == sdcp_pkg::OP_SAMPLE) begin
            last_sample = smp;
        end else if (ch == sdcp_pkg::CH_CR || ch == sdcp_pkg::CH_LF) begin
            if (line_len != 0) begin
                if (first_kind == sdcp_pkg::KIND_SET) begin
                    if (digits_ok && digit_accum <= sdcp_pkg::DUTY_MAX) begin
                        manual_duty        = digit_accum[7:0];
                        manual_override    = 1'b1;
                        res.event_code     = sdcp_pkg::EV_SET;
                        res.accepted_value = digit_accum[7:0];
                    end else begin
                        res.event_code = sdcp_pkg::EV_INVALID;
                    end
                end else if (first_kind == sdcp_pkg::KIND_AUTO) begin
                    manual_override = 1'b0;
                    res.event_code  = sdcp_pkg::EV_SAMPLE;
                end
            end
            restart_line();
        end else if (line_len < LINE_BYTES - 1) begin
            if (line_len == 0) begin
                if (ch == sdcp_pkg::CH_S_UP || ch == sdcp_pkg::CH_S_LO)
                    first_kind = sdcp_pkg::KIND_SET;
                else if (ch == sdcp_pkg::CH_A_UP || ch == sdcp_pkg::CH_A_LO)
                    first_kind = sdcp_pkg::KIND_AUTO;
                else
                    first_kind = sdcp_pkg::KIND_OTHER;
            end else if (digits_ok) begin
                // Once a non-digit shows up the accumulator is frozen.
                if (ch >= sdcp_pkg::CH_ZERO && ch <= sdcp_pkg::CH_NINE)
                    digit_accum = digit_accum * 16'd10 + 16'(ch - sdcp_pkg::CH_ZERO);
                else
                    digits_ok = 1'b0;
            end
            line_len++;
        end else begin
            restart_line();
            res.event_code = sdcp_pkg::EV_TOO_LONG;
        end
        res.duty        = manual_override ? manual_duty : last_sample[9:2];
        res.manual_mode = manual_override;
        expected_reports.push_back(res);
    endtask

    // Driver: offers the next queued command whenever the channel is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_opcode     <= sdcp_pkg::OP_BYTE;
            i_rx_byte    <= 8'd0;
            i_adc_sample <= 10'd0;
        end else begin
            if (i_valid && o_ready)
                advance_parser(i_opcode, i_rx_byte, i_adc_sample);
            if (!i_valid || o_ready) begin
                if (pending_commands.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_cmd     = pending_commands.pop_front();
                    i_opcode     <= next_cmd.opcode;
                    i_rx_byte    <= next_cmd.rx_byte;
                    i_adc_sample <= next_cmd.adc_sample;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            hold_left  <= 0;
            hold_taken <= hold_request;
        end else if (hold_request != hold_taken) begin
            hold_taken <= hold_request;
            hold_left  <= LONG_HOLD;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Monitor: every result transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result with nothing expected:", $time,
                         " ev=%0d val=%0d duty=%0d man=%0d",
                         o_event_code, o_accepted_value, o_duty, o_manual_mode);
                mismatch_count <= mismatch_count + 1;
            end else if ({o_event_code, o_accepted_value, o_duty, o_manual_mode}
                         !== expected_reports[0]) begin
                $display("%0t: expected ev=%0d val=%0d duty=%0d man=%0d,",
                         $time, expected_reports[0].event_code,
                         expected_reports[0].accepted_value, expected_reports[0].duty,
                         expected_reports[0].manual_mode,
                         " got ev=%0d val=%0d duty=%0d man=%0d",
                         o_event_code, o_accepted_value, o_duty, o_manual_mode);
                mismatch_count <= mismatch_count + 1;
                void'(expected_reports.pop_front());
            end else begin
                void'(expected_reports.pop_front());
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] ch);
        t_cmd_item cmd;
        cmd.opcode     = sdcp_pkg::OP_BYTE;
        cmd.rx_byte    = ch;
        cmd.adc_sample = 10'($urandom_range(0, 1023));
        pending_commands.push_back(cmd);
        queued_total++;
    endtask

    task automatic push_sample(input logic [9:0] smp);
        t_cmd_item cmd;
        cmd.opcode     = sdcp_pkg::OP_SAMPLE;
        cmd.rx_byte    = 8'($urandom_range(0, 255));
        cmd.adc_sample = smp;
        pending_commands.push_back(cmd);
        queued_total++;
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_byte(txt[i]);
    endtask

    // A character inside a random line; now and then a sample slips in ahead of it.
    task automatic push_mixed(input logic [7:0] ch);
        if ($urandom_range(0, 19) == 0)
            push_sample(10'($urandom_range(0, 1023)));
        push_byte(ch);
    endtask

    function automatic logic [7:0] any_terminator();
        return ($urandom_range(0, 1) != 0) ? sdcp_pkg::CH_CR : sdcp_pkg::CH_LF;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == sdcp_pkg::CH_CR || c == sdcp_pkg::CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] any_digit();
        return sdcp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic queue_random_line();
        int         kind;
        int         n;
        string      txt;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // Well-formed set command, often with a value that fits.
            push_mixed(($urandom_range(0, 1) != 0) ? sdcp_pkg::CH_S_UP : sdcp_pkg::CH_S_LO);
            if ($urandom_range(0, 1) != 0) begin
                n = $urandom_range(0, 2);
                repeat (n) push_mixed(sdcp_pkg::CH_ZERO);
                txt = $sformatf("%0d", $urandom_range(0, 255));
                for (int i = 0; i < txt.len(); i++)
                    push_mixed(txt[i]);
            end else begin
                repeat ($urandom_range(0, 14)) push_mixed(any_digit());
            end
            push_mixed(any_terminator());
        end else if (kind < 50) begin
            push_mixed(($urandom_range(0, 1) != 0) ? sdcp_pkg::CH_A_UP : sdcp_pkg::CH_A_LO);
            repeat ($urandom_range(0, 4)) push_mixed(any_char());
            push_mixed(any_terminator());
        end else if (kind < 60) begin
            // Set command, usually broken by a non-digit.
            push_mixed(($urandom_range(0, 1) != 0) ? sdcp_pkg::CH_S_UP : sdcp_pkg::CH_S_LO);
            repeat ($urandom_range(0, 4)) push_mixed(any_digit());
            push_mixed(any_char());
            repeat ($urandom_range(0, 3)) push_mixed(any_char());
            push_mixed(any_terminator());
        end else if (kind < 68) begin
            // Line at or past the length limit.
            case ($urandom_range(0, 2))
                0: c = sdcp_pkg::CH_S_UP;
                1: c = sdcp_pkg::CH_A_LO;
                default: c = any_char();
            endcase
            push_mixed(c);
            repeat (LINE_BYTES - 2)
                push_mixed(($urandom_range(0, 3) != 0) ? any_digit() : any_char());
            n = $urandom_range(0, 4);
            repeat (n) push_mixed(any_char());
            if (n == 0 || $urandom_range(0, 1) != 0)
                push_mixed(any_terminator());
        end else if (kind < 76) begin
            push_mixed(any_char());
            repeat ($urandom_range(0, 3)) push_mixed(any_char());
            push_mixed(any_terminator());
        end else if (kind < 88) begin
            repeat ($urandom_range(1, 3)) push_sample(10'($urandom_range(0, 1023)));
        end else begin
            repeat ($urandom_range(1, 4)) push_mixed(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_random(input int count);
        int start;
        start = queued_total;
        while (queued_total - start < count)
            queue_random_line();
    endtask

    task automatic wait_all_done();
        @(negedge i_clk);
        while (pending_commands.size() != 0 || i_valid || expected_reports.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        int idle_mix[4]  = '{0, 67, 0, 10};
        int stall_mix[4] = '{0, 0, 67, 10};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed lines.
        push_sample(10'd1023);
        push_byte("X");
        push_byte(8'hFF);
        push_byte(8'h00);
        repeat (13) push_byte("7");
        push_byte(sdcp_pkg::CH_LF);
        push_text("S65791");
        push_byte(sdcp_pkg::CH_CR);
        push_sample(10'd0);
        push_byte(sdcp_pkg::CH_S_LO);
        push_byte(sdcp_pkg::CH_LF);
        push_text("Sq");
        push_byte(sdcp_pkg::CH_CR);
        push_byte(sdcp_pkg::CH_A_LO);
        push_byte(sdcp_pkg::CH_CR);
        push_byte("X");
        push_byte(sdcp_pkg::CH_LF);
        wait_all_done();

        // Receiver holds off while the sender keeps offering, so the block backs up.
        hold_request = ~hold_request;
        queue_random(40);
        wait_all_done();

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = idle_mix[p];
            receiver_stall_pct = stall_mix[p];
            queue_random(PHASE_ITEMS);
            wait_all_done();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
